@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, widths and constants of the pin touch detector.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // Default grid geometry and history depth.
   localparam int DEF_GRID_COLS  = 48;
   localparam int DEF_GRID_ROWS  = 24;
   localparam int DEF_WINDOW_LEN = 4;

   // Field widths of the transactions.
   localparam int X_W      = 6;
   localparam int Y_W      = 5;
   localparam int HEIGHT_W = 8;
   localparam int ERR_W    = 9;

   // Reset values.
   localparam logic [HEIGHT_W-1:0] WIN_RESET      = 8'd210;
   localparam logic [7:0]          TOLERANCE_RST  = 8'd2;
   localparam logic [7:0]          THRESHOLD_RST  = 8'd21;

   // Register file of the configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      CSR_FLAT_TOLERANCE  = 1'b0,
      CSR_TOUCH_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

@@ rtl/ptd_req_if.sv @@
// ----------------------------------------------------------------------------
// ptd_req_if
// Valid/ready channel carrying one pin sample per transaction.
// ----------------------------------------------------------------------------
interface ptd_req_if
   import ptd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [X_W-1:0]      pin_x;
   logic [Y_W-1:0]      pin_y;
   logic [HEIGHT_W-1:0] commanded_height;
   logic [HEIGHT_W-1:0] measured_height;
   logic                frame_end;

   modport source (output valid, pin_x, pin_y, commanded_height, measured_height,
                   frame_end, input ready);
   modport sink   (input valid, pin_x, pin_y, commanded_height, measured_height,
                   frame_end, output ready);
endinterface

@@ rtl/ptd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ptd_rsp_if
// Valid/ready channel carrying one pin verdict per transaction.
// ----------------------------------------------------------------------------
interface ptd_rsp_if
   import ptd_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] height_error;
   logic                    pin_flat;
   logic                    pin_touched;
   logic                    frame_done;
   logic                    any_touched;
   logic [X_W-1:0]          least_touched_x;
   logic [Y_W-1:0]          least_touched_y;

   modport source (output valid, height_error, pin_flat, pin_touched, frame_done,
                   any_touched, least_touched_x, least_touched_y, input ready);
   modport sink   (input valid, height_error, pin_flat, pin_touched, frame_done,
                   any_touched, least_touched_x, least_touched_y, output ready);
endinterface

@@ rtl/pin_touch_detector.sv @@
// ----------------------------------------------------------------------------
// pin_touch_detector
// Per-pin flatness and touch detection with per-frame touch summary.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on req carries one pin sample (position, commanded and
// measured height, end-of-frame flag); each produces exactly one transaction
// on rsp, in order. The command history of all pins sits in one synchronous
// memory, one row per pin holding its last WINDOW_LEN commands.
// The memory read is registered at the accepting edge along with the sample in
// the processing stage, which forms the window update, writes it back and
// registers the verdict in the output register. A new sample is taken every
// cycle unless rsp stalls; back-to-back samples of the same pin are served by
// forwarding the row just written, so throughput is one sample per cycle.
// After reset the history memory is swept to 210 in every slot, one row a
// cycle, over all GRID_COLS*GRID_ROWS rows (1152 by default); req.ready stays
// low during the sweep, while csr writes are taken at once.
// When rsp is stalled the result holds in its output register and one more
// sample is still taken into the processing stage before req.ready drops.
// Configuration: flat_tolerance at byte address 0, touch_threshold at 4.
// ----------------------------------------------------------------------------
module pin_touch_detector
   import ptd_pkg::*;
#(
   parameter int GRID_COLS  = DEF_GRID_COLS,
   parameter int GRID_ROWS  = DEF_GRID_ROWS,
   parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   ptd_req_if.sink               req,
   ptd_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PIN_COUNT = GRID_COLS * GRID_ROWS;
   localparam int AW        = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int WW        = WINDOW_LEN * HEIGHT_W;
   localparam int CW        = $clog2(GRID_COLS + 1);
   localparam int RW        = $clog2(GRID_ROWS + 1);

   localparam logic [AW-1:0] LAST_ROW = AW'(PIN_COUNT - 1);
   localparam logic [CW-1:0] COL_NONE = CW'(GRID_COLS);
   localparam logic [RW-1:0] ROW_NONE = RW'(GRID_ROWS);

   // Configuration registers.
   logic [7:0]    tolerance_ff, tolerance_in;
   logic [7:0]    threshold_ff, threshold_in;
   csr_index_type csr_index;
   logic          csr_write;

   // Clearing sweep.
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // History memory.
   logic [WW-1:0] window_mem_ff [PIN_COUNT];
   logic [WW-1:0] win_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;

   // Input decode.
   logic          req_acc;
   logic          req_in_grid;
   logic [AW-1:0] req_addr;

   // Processing stage.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_adv;
   logic [X_W-1:0]      s1_x_ff, s1_x_in;
   logic [Y_W-1:0]      s1_y_ff, s1_y_in;
   logic [HEIGHT_W-1:0] s1_cmd_ff, s1_cmd_in;
   logic [HEIGHT_W-1:0] s1_meas_ff, s1_meas_in;
   logic                s1_last_ff, s1_last_in;
   logic                s1_in_grid_ff, s1_in_grid_in;
   logic [AW-1:0]       s1_addr_ff, s1_addr_in;

   // Forwarding of a row written in the cycle it was read.
   logic          fwd_hit_ff, fwd_hit_in;
   logic [WW-1:0] fwd_win_ff, fwd_win_in;

   // Frame aggregates.
   logic          seen_ff, seen_in;
   logic [CW-1:0] min_col_ff, min_col_in;
   logic [RW-1:0] min_row_ff, min_row_in;

   // Verdict of the processing stage.
   logic [WW-1:0]           old_win;
   logic [WW-1:0]           new_win;
   logic [HEIGHT_W-1:0]     win_hi;
   logic [HEIGHT_W-1:0]     win_lo;
   logic signed [ERR_W-1:0] err;
   logic [HEIGHT_W-1:0]     mag;
   logic                    flat;
   logic                    touched;
   logic                    seen_now;
   logic [CW-1:0]           col_now;
   logic [RW-1:0]           row_now;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0] rsp_err_ff, rsp_err_in;
   logic                    rsp_flat_ff, rsp_flat_in;
   logic                    rsp_touched_ff, rsp_touched_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic                    rsp_any_ff, rsp_any_in;
   logic [X_W-1:0]          rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]          rsp_y_ff, rsp_y_in;

   // Configuration port: no wait states, writes at the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      tolerance_in = tolerance_ff;
      threshold_in = threshold_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FLAT_TOLERANCE:  tolerance_in = csr_pwdata[7:0];
            CSR_TOUCH_THRESHOLD: threshold_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_FLAT_TOLERANCE:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, tolerance_ff};
         CSR_TOUCH_THRESHOLD: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, threshold_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // Clearing sweep after reset, one row per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_ROW) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Input handshake and row address.
   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_acc     = req.valid && req.ready;
   assign req_in_grid = (int'(req.pin_x) < GRID_COLS) && (int'(req.pin_y) < GRID_ROWS);
   assign req_addr    = AW'(int'(req.pin_y) * GRID_COLS + int'(req.pin_x));

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_x_in       = s1_x_ff;
      s1_y_in       = s1_y_ff;
      s1_cmd_in     = s1_cmd_ff;
      s1_meas_in    = s1_meas_ff;
      s1_last_in    = s1_last_ff;
      s1_in_grid_in = s1_in_grid_ff;
      s1_addr_in    = s1_addr_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_acc) begin
         s1_valid_in   = 1'b1;
         s1_x_in       = req.pin_x;
         s1_y_in       = req.pin_y;
         s1_cmd_in     = req.commanded_height;
         s1_meas_in    = req.measured_height;
         s1_last_in    = req.frame_end;
         s1_in_grid_in = req_in_grid;
         s1_addr_in    = req_addr;
      end
   end

   // A row written at the edge where the next sample of the same pin is read
   // would be read stale, so the written row is kept aside for that sample.
   assign fwd_hit_in = req_acc && s1_adv && s1_in_grid_ff && (req_addr == s1_addr_ff);
   assign fwd_win_in = new_win;

   // Window shift: the new command enters slot 0, the oldest drops out.
   assign old_win = fwd_hit_ff ? fwd_win_ff : win_rd_ff;

   generate
      if (WINDOW_LEN > 1) begin : g_shift
         assign new_win = {old_win[WW-HEIGHT_W-1:0], s1_cmd_ff};
      end else begin : g_single
         assign new_win = s1_cmd_ff;
      end
   endgenerate

   // Spread of the window across its slots.
   always_comb begin
      win_hi = '0;
      win_lo = '1;
      for (int k = 0; k < WINDOW_LEN; k++) begin
         if (new_win[k*HEIGHT_W +: HEIGHT_W] > win_hi) begin
            win_hi = new_win[k*HEIGHT_W +: HEIGHT_W];
         end
         if (new_win[k*HEIGHT_W +: HEIGHT_W] < win_lo) begin
            win_lo = new_win[k*HEIGHT_W +: HEIGHT_W];
         end
      end
   end

   // Height error, flatness and touch verdict.
   assign err     = $signed({1'b0, s1_cmd_ff}) - $signed({1'b0, s1_meas_ff});
   assign mag     = err[ERR_W-1] ? HEIGHT_W'(-err) : err[HEIGHT_W-1:0];
   assign flat    = s1_in_grid_ff && ((win_hi - win_lo) <= tolerance_ff);
   assign touched = flat && (mag > threshold_ff);

   // Running frame aggregates including this pin.
   always_comb begin
      seen_now = seen_ff;
      col_now  = min_col_ff;
      row_now  = min_row_ff;
      if (touched) begin
         seen_now = 1'b1;
         if (CW'(s1_x_ff) < min_col_ff) begin
            col_now = CW'(s1_x_ff);
         end
         if (RW'(s1_y_ff) < min_row_ff) begin
            row_now = RW'(s1_y_ff);
         end
      end
   end

   always_comb begin
      seen_in    = seen_ff;
      min_col_in = min_col_ff;
      min_row_in = min_row_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            seen_in    = 1'b0;
            min_col_in = COL_NONE;
            min_row_in = ROW_NONE;
         end else begin
            seen_in    = seen_now;
            min_col_in = col_now;
            min_row_in = row_now;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_flat_in    = rsp_flat_ff;
      rsp_touched_in = rsp_touched_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_any_in     = rsp_any_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_valid_in   = 1'b1;
         rsp_err_in     = err;
         rsp_flat_in    = flat;
         rsp_touched_in = touched;
         rsp_done_in    = s1_last_ff;
         rsp_any_in     = seen_now;
         rsp_x_in       = X_W'(col_now);
         rsp_y_in       = Y_W'(row_now);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.height_error    = rsp_err_ff;
   assign rsp.pin_flat        = rsp_flat_ff;
   assign rsp.pin_touched     = rsp_touched_ff;
   assign rsp.frame_done      = rsp_done_ff;
   assign rsp.any_touched     = rsp_any_ff;
   assign rsp.least_touched_x = rsp_x_ff;
   assign rsp.least_touched_y = rsp_y_ff;

   // Memory write port: the clearing sweep, else the stage's write-back.
   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = {WINDOW_LEN{WIN_RESET}};
      end else begin
         mem_we    = s1_adv && s1_in_grid_ff;
         mem_waddr = s1_addr_ff;
         mem_wdata = new_win;
      end
   end

   // History memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         win_rd_ff <= window_mem_ff[req_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RST;
         threshold_ff <= THRESHOLD_RST;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         min_col_ff   <= COL_NONE;
         min_row_ff   <= ROW_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         tolerance_ff <= tolerance_in;
         threshold_ff <= threshold_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= req_acc ? fwd_hit_in : fwd_hit_ff;
         seen_ff      <= seen_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_x_ff        <= s1_x_in;
      s1_y_ff        <= s1_y_in;
      s1_cmd_ff      <= s1_cmd_in;
      s1_meas_ff     <= s1_meas_in;
      s1_last_ff     <= s1_last_in;
      s1_in_grid_ff  <= s1_in_grid_in;
      s1_addr_ff     <= s1_addr_in;
      if (fwd_hit_in) begin
         fwd_win_ff <= fwd_win_in;
      end
      rsp_err_ff     <= rsp_err_in;
      rsp_flat_ff    <= rsp_flat_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_any_ff     <= rsp_any_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
   end

endmodule
